// ----- rtl/core/sbsm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbsm_pkg
// Shared types and constants for the serial bank switch mapper core.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  localparam int CHR_RAM_DEPTH = 8192;
  localparam int CHR_RAM_AW    = $clog2(CHR_RAM_DEPTH);
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PW       = $clog2(FIFO_DEPTH);

  localparam int PRG_BANK_W = 4;
  localparam int CHR_BANK_W = 5;
  localparam int PRG_ADDR_W = 18;
  localparam int CHR_ADDR_W = 17;
  localparam int CFG_DATA_W = 5;

  localparam logic [2:0] SHIFT_LEN = 3'd5;

  typedef enum logic [1:0] {
    FUNC_PRG_RD = 2'd0,
    FUNC_PRG_WR = 2'd1,
    FUNC_CHR_RD = 2'd2,
    FUNC_CHR_WR = 2'd3
  } sbsm_func_t;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_ROM = 2'd1,
    TGT_CHR_ROM = 2'd2,
    TGT_CHR_RAM = 2'd3
  } sbsm_target_t;

  typedef enum logic [1:0] {
    CFG_USES_CHR_RAM  = 2'd0,
    CFG_PRG_BANK_MASK = 2'd1,
    CFG_CHR_BANK_MASK = 2'd2,
    CFG_UNUSED        = 2'd3
  } sbsm_cfg_idx_t;

  // register decode of the fifth serial write, from address bits 14:13
  typedef enum logic [1:0] {
    LOAD_CONTROL = 2'd0,
    LOAD_CHR_LO  = 2'd1,
    LOAD_CHR_HI  = 2'd2,
    LOAD_PRG     = 2'd3
  } sbsm_load_t;

  typedef struct packed {
    logic we;
    logic rd;
  } sbsm_ram_ctl_t;

  typedef struct packed {
    sbsm_target_t            target;
    logic [PRG_ADDR_W-1:0]   prg_rom_address;
    logic [CHR_ADDR_W-1:0]   chr_rom_address;
    logic [1:0]              mirroring;
    logic                    mirroring_changed;
    logic                    write_rejected;
  } sbsm_res_t;

  typedef struct packed {
    sbsm_res_t   res;
    logic [7:0]  read_data;
  } sbsm_out_t;

endpackage

// ----- rtl/core/serial_bank_switch_mapper_core.sv -----
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core
// Serial-load bank switching mapper with internal 8KB character RAM.
// ----------------------------------------------------------------------------
// An accepted input word passes the RAM stage, then the result queue.
// Throughput: one word per cycle unless in_stall; the character RAM port does
// one access per word and its registered read sets the extra pipeline stage.
// A 4-entry result queue keeps in_stall a decode of local registers only.
// Reset: mapper registers and configuration return to power-on values;
// character RAM contents stay undefined until written (no clearing pass).
module serial_bank_switch_mapper_core import sbsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [15:0]           in_address,
  input  logic [7:0]            in_write_data,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_target,
  output logic [PRG_ADDR_W-1:0] out_prg_rom_address,
  output logic [CHR_ADDR_W-1:0] out_chr_rom_address,
  output logic [7:0]            out_read_data,
  output logic [1:0]            out_mirroring,
  output logic                  out_mirroring_changed,
  output logic                  out_write_rejected,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic            in_accept;
  logic            pop;
  sbsm_res_t       acc_res;
  sbsm_ram_ctl_t   ram_ctl;

  logic [7:0]      chr_ram [CHR_RAM_DEPTH];
  logic [7:0]      ram_q_r;

  logic            s1_valid_r;
  sbsm_res_t       s1_res_r;
  logic            s1_rd_r;

  sbsm_out_t       fifo_r [FIFO_DEPTH];
  sbsm_out_t       head;
  sbsm_out_t       s1_word;
  logic [FIFO_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PW:0]   count_r, count_nxt;
  logic [FIFO_PW+1:0] credit;

  assign cfg_ready = 1'b1;

  // stall while the queue plus the word in flight could fill every entry
  assign credit    = {1'b0, count_r} + {{(FIFO_PW+1){1'b0}}, s1_valid_r};
  assign in_stall  = (credit >= (FIFO_PW+2)'(FIFO_DEPTH));
  assign in_accept = in_valid && !in_stall;

  sbsm_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .acc_valid  (in_accept),
    .func       (in_func),
    .address    (in_address),
    .write_data (in_write_data),
    .res        (acc_res),
    .ram_ctl    (ram_ctl)
  );

  // single-port character RAM: write lands at the accept edge, so a later
  // read of the same entry sees it without forwarding
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (ram_ctl.we) begin
        chr_ram[in_address[CHR_RAM_AW-1:0]] <= in_write_data;
      end
      ram_q_r <= chr_ram[in_address[CHR_RAM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res_r <= acc_res;
      s1_rd_r  <= ram_ctl.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  assign s1_word.res       = s1_res_r;
  assign s1_word.read_data = s1_rd_r ? ram_q_r : 8'd0;

  // result queue
  assign head      = fifo_r[rd_ptr_r];
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_nxt = count_r;
    if (s1_valid_r && !pop) begin
      count_nxt = count_r + (FIFO_PW+1)'(1);
    end else if (!s1_valid_r && pop) begin
      count_nxt = count_r - (FIFO_PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      fifo_r[wr_ptr_r] <= s1_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (s1_valid_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign out_target            = head.res.target;
  assign out_prg_rom_address   = head.res.prg_rom_address;
  assign out_chr_rom_address   = head.res.chr_rom_address;
  assign out_read_data         = head.read_data;
  assign out_mirroring         = head.res.mirroring;
  assign out_mirroring_changed = head.res.mirroring_changed;
  assign out_write_rejected    = head.res.write_rejected;

  no_overflow_a: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (count_r != (FIFO_PW+1)'(FIFO_DEPTH) || pop))
    else $error("result queue overflow");

  count_range_a: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_PW+1)'(FIFO_DEPTH))
    else $error("result queue count out of range");

  accept_advances_a: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted word did not reach the RAM stage");

  changed_no_target_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mirroring_changed) |-> (out_target == TGT_NONE))
    else $error("control load word carries a target");

endmodule

// ----- rtl/core/sbsm_regs.sv -----
// ----------------------------------------------------------------------------
// sbsm_regs
// Mapper register file: serial loader, bank selects, configuration and
// address translation for one bus access.
// ----------------------------------------------------------------------------
module sbsm_regs import sbsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc_valid,
  input  logic [1:0]            func,
  input  logic [15:0]           address,
  input  logic [7:0]            write_data,
  output sbsm_res_t             res,
  output sbsm_ram_ctl_t         ram_ctl
);

  logic                  uses_chr_ram_r;
  logic [PRG_BANK_W-1:0] prg_bank_mask_r;
  logic [CHR_BANK_W-1:0] chr_bank_mask_r;

  logic [4:0]            shift_value_r, shift_value_nxt;
  logic [2:0]            shift_count_r, shift_count_nxt;
  logic [1:0]            mirror_mode_r, mirror_mode_nxt;
  logic                  chr_mode_r, chr_mode_nxt;
  logic [1:0]            prg_mode_r, prg_mode_nxt;
  logic [PRG_BANK_W-1:0] prg_select_r, prg_select_nxt;
  logic [CHR_BANK_W-1:0] chr_sel_lo_r, chr_sel_lo_nxt;
  logic [CHR_BANK_W-1:0] chr_sel_hi_r, chr_sel_hi_nxt;

  logic [PRG_BANK_W-1:0] prg_first, prg_second, prg_bank;
  logic [CHR_BANK_W-1:0] chr_first, chr_second, chr_bank;
  logic [4:0]            sv_shift;
  logic [2:0]            cnt_inc;
  sbsm_func_t            fn;
  sbsm_load_t            load_sel;
  logic                  prg_space;

  // bank derivation follows the current selects, modes and mask
  always_comb begin
    if (prg_mode_r[1] == 1'b0) begin
      prg_first  = {prg_select_r[PRG_BANK_W-1:1], 1'b0};
      prg_second = {prg_select_r[PRG_BANK_W-1:1], 1'b1};
    end else if (prg_mode_r[0] == 1'b0) begin
      prg_first  = '0;
      prg_second = prg_select_r;
    end else begin
      prg_first  = prg_select_r;
      prg_second = prg_bank_mask_r;
    end
    if (chr_mode_r == 1'b0) begin
      chr_first  = {chr_sel_lo_r[CHR_BANK_W-1:1], 1'b0};
      chr_second = {chr_sel_lo_r[CHR_BANK_W-1:1], 1'b1};
    end else begin
      chr_first  = chr_sel_lo_r;
      chr_second = chr_sel_hi_r;
    end
  end

  assign prg_bank  = (address[14] ? prg_second : prg_first) & prg_bank_mask_r;
  assign chr_bank  = (address[12] ? chr_second : chr_first) & chr_bank_mask_r;
  assign sv_shift  = {write_data[0], shift_value_r[4:1]};
  assign cnt_inc   = shift_count_r + 3'd1;
  assign fn        = sbsm_func_t'(func);
  assign load_sel  = sbsm_load_t'(address[14:13]);
  assign prg_space = address[15];

  always_comb begin
    shift_value_nxt = shift_value_r;
    shift_count_nxt = shift_count_r;
    mirror_mode_nxt = mirror_mode_r;
    chr_mode_nxt    = chr_mode_r;
    prg_mode_nxt    = prg_mode_r;
    prg_select_nxt  = prg_select_r;
    chr_sel_lo_nxt  = chr_sel_lo_r;
    chr_sel_hi_nxt  = chr_sel_hi_r;

    res.target            = TGT_NONE;
    res.prg_rom_address   = '0;
    res.chr_rom_address   = '0;
    res.mirroring_changed = 1'b0;
    res.write_rejected    = 1'b0;
    ram_ctl.we            = 1'b0;
    ram_ctl.rd            = 1'b0;

    case (fn)
      FUNC_PRG_RD: begin
        if (prg_space) begin
          res.target          = TGT_PRG_ROM;
          res.prg_rom_address = {prg_bank, address[13:0]};
        end
      end
      FUNC_PRG_WR: begin
        if (prg_space) begin
          if (write_data[7]) begin
            shift_value_nxt = '0;
            shift_count_nxt = '0;
            prg_mode_nxt    = 2'd3;
          end else if (cnt_inc >= SHIFT_LEN) begin
            shift_value_nxt = '0;
            shift_count_nxt = '0;
            unique case (load_sel)
              LOAD_CONTROL: begin
                mirror_mode_nxt       = sv_shift[1:0];
                prg_mode_nxt          = sv_shift[3:2];
                chr_mode_nxt          = sv_shift[4];
                res.mirroring_changed = 1'b1;
              end
              LOAD_CHR_LO: chr_sel_lo_nxt = sv_shift;
              LOAD_CHR_HI: chr_sel_hi_nxt = sv_shift;
              LOAD_PRG:    prg_select_nxt = sv_shift[PRG_BANK_W-1:0];
              default:     prg_select_nxt = prg_select_r;
            endcase
          end else begin
            shift_value_nxt = sv_shift;
            shift_count_nxt = cnt_inc;
          end
        end
      end
      FUNC_CHR_RD: begin
        if (uses_chr_ram_r) begin
          res.target = TGT_CHR_RAM;
          ram_ctl.rd = 1'b1;
        end else begin
          res.target          = TGT_CHR_ROM;
          res.chr_rom_address = {chr_bank, address[11:0]};
        end
      end
      FUNC_CHR_WR: begin
        if (uses_chr_ram_r) begin
          res.target = TGT_CHR_RAM;
          ram_ctl.we = 1'b1;
        end else begin
          res.write_rejected = 1'b1;
        end
      end
      default: res.target = TGT_NONE;
    endcase

    res.mirroring = mirror_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uses_chr_ram_r  <= 1'b0;
      prg_bank_mask_r <= '1;
      chr_bank_mask_r <= '1;
      shift_value_r   <= '0;
      shift_count_r   <= '0;
      mirror_mode_r   <= 2'd3;
      chr_mode_r      <= 1'b0;
      prg_mode_r      <= 2'd3;
      prg_select_r    <= '0;
      chr_sel_lo_r    <= '0;
      chr_sel_hi_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (sbsm_cfg_idx_t'(cfg_index))
          CFG_USES_CHR_RAM:  uses_chr_ram_r  <= cfg_data[0];
          CFG_PRG_BANK_MASK: prg_bank_mask_r <= cfg_data[PRG_BANK_W-1:0];
          CFG_CHR_BANK_MASK: chr_bank_mask_r <= cfg_data[CHR_BANK_W-1:0];
          default:           uses_chr_ram_r  <= uses_chr_ram_r;
        endcase
      end
      if (acc_valid) begin
        shift_value_r <= shift_value_nxt;
        shift_count_r <= shift_count_nxt;
        mirror_mode_r <= mirror_mode_nxt;
        chr_mode_r    <= chr_mode_nxt;
        prg_mode_r    <= prg_mode_nxt;
        prg_select_r  <= prg_select_nxt;
        chr_sel_lo_r  <= chr_sel_lo_nxt;
        chr_sel_hi_r  <= chr_sel_hi_nxt;
      end
    end
  end

  shift_count_range_a: assert property (@(posedge clk) disable iff (!rst_n)
    shift_count_r < SHIFT_LEN)
    else $error("serial load count ran past the fifth bit");

  ram_one_op_a: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_ctl.we && ram_ctl.rd))
    else $error("character RAM read and write issued together");

  rejected_no_target_a: assert property (@(posedge clk) disable iff (!rst_n)
    res.write_rejected |-> (res.target == TGT_NONE && !uses_chr_ram_r))
    else $error("rejected write carries a target");

endmodule
